### src/clt_pkg.sv
// Package for the command-line tokenizer: parse modes, character codes,
// item and state types. No dependencies.
package clt_pkg;

  localparam int ArgW = 3;
  localparam logic [ArgW-1:0] ArgCap = 3'd7;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    MODE_WS,
    MODE_TOKEN,
    MODE_STRING,
    MODE_ESCAPE
  } mode_t;

  typedef struct packed {
    mode_t parse_mode;
    mode_t saved_mode;
    logic [ArgW-1:0] arg_counter;
  } state_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic token_start;
    logic [ArgW-1:0] arg_index;
    logic [ArgW-1:0] arg_total;
    logic segment_end;
    logic line_end;
    logic arg_overflow;
  } result_t;

endpackage

### src/clt_if.sv
// Handshake channels of the command-line tokenizer: character items in,
// result items out. Depends on clt_pkg.
interface clt_char_if;
  logic valid;
  logic ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface clt_result_if
  import clt_pkg::*;
;
  logic valid;
  logic ready;
  logic [7:0] char_out;
  logic token_start;
  logic [ArgW-1:0] arg_index;
  logic [ArgW-1:0] arg_total;
  logic segment_end;
  logic line_end;
  logic arg_overflow;

  modport source (
    output valid, output char_out, output token_start, output arg_index,
    output arg_total, output segment_end, output line_end, output arg_overflow,
    input ready
  );
  modport sink (
    input valid, input char_out, input token_start, input arg_index,
    input arg_total, input segment_end, input line_end, input arg_overflow,
    output ready
  );
endinterface

### src/clt_step.sv
// Per-character decision of the tokenizer: classifies one byte against the
// parse state and gives the result item and the next state. Depends on clt_pkg.
module clt_step
  import clt_pkg::*;
(
  input  logic [7:0]      char_in,
  input  logic [ArgW-1:0] arg_limit,
  input  state_t          state,
  output result_t         result,
  output state_t          state_next
);

  always_comb begin
    logic want_start;
    mode_t mode_next;
    mode_t saved_next;
    logic [ArgW-1:0] count_next;

    want_start = 1'b0;
    mode_next = state.parse_mode;
    saved_next = state.saved_mode;
    count_next = state.arg_counter;
    result = '0;
    result.char_out = char_in;

    if (char_in == CHAR_NUL) begin
      result.line_end = 1'b1;
      result.char_out = CHAR_NUL;
    end else if (char_in == CHAR_SEMI && state.parse_mode != MODE_STRING &&
                 state.parse_mode != MODE_ESCAPE) begin
      result.segment_end = 1'b1;
      result.char_out = CHAR_NUL;
    end else if (state.parse_mode == MODE_ESCAPE) begin
      mode_next = state.saved_mode;
    end else if (state.parse_mode == MODE_STRING) begin
      if (char_in == CHAR_QUOTE) begin
        mode_next = MODE_WS;
        result.char_out = CHAR_NUL;
      end
    end else if (char_in == CHAR_SPACE || char_in == CHAR_TAB) begin
      mode_next = MODE_WS;
      result.char_out = CHAR_NUL;
    end else if (char_in == CHAR_QUOTE) begin
      mode_next = MODE_STRING;
      result.char_out = CHAR_NUL;
      want_start = 1'b1;
    end else if (char_in == CHAR_BSLASH) begin
      saved_next = state.parse_mode;
      mode_next = MODE_ESCAPE;
    end else begin
      want_start = (state.parse_mode == MODE_WS);
      mode_next = MODE_TOKEN;
    end

    if (want_start) begin
      if (state.arg_counter < arg_limit) begin
        result.token_start = 1'b1;
        result.arg_index = state.arg_counter;
        count_next = state.arg_counter + 3'd1;
      end else begin
        result.arg_overflow = 1'b1;
      end
    end
    result.arg_total = count_next;

    if (result.line_end || result.segment_end) begin
      state_next.parse_mode = MODE_WS;
      state_next.saved_mode = MODE_WS;
      state_next.arg_counter = '0;
    end else begin
      state_next.parse_mode = mode_next;
      state_next.saved_mode = saved_next;
      state_next.arg_counter = count_next;
    end
  end

endmodule

### src/command_line_tokenizer.sv
// Top level of the command-line tokenizer: input register, decision logic,
// parse state and result register. Depends on clt_pkg, clt_if and clt_step.
//
// The block takes one command-line byte per item on the chars channel and
// gives one result item per byte on the tokens channel, in order. Each result
// holds the byte to store (zero where a separator or quote becomes a
// terminator), the argument start flag with its index, the running argument
// count, and the segment end, line end and overflow flags.
// An item accepted on chars is held in the input register and then in the
// result register before it shows on tokens.
// With tokens ready held high, a new item is taken every cycle.
// The parse state is updated as an item moves from the input register into
// the result register, so items are decided strictly in arrival order.
// Reset clears both register stages and returns the parser to whitespace mode
// with a zero argument count. When the receiver stalls, the result register
// holds its item, the input register fills, and chars.ready falls only once
// both are occupied; no item is lost or repeated.
module command_line_tokenizer
  import clt_pkg::*;
#(
  parameter int MAX_ARGS = 7
) (
  input logic clk,
  input logic rst,
  clt_char_if.sink chars,
  clt_result_if.source tokens
);

  localparam logic [ArgW-1:0] ArgLimit =
    (MAX_ARGS > 7) ? ArgCap : ArgW'(MAX_ARGS);

  logic hold_valid;
  logic [7:0] hold_char;
  logic result_valid;
  result_t result;
  result_t result_next;
  state_t state;
  state_t state_next;
  logic advance;

  assign advance = hold_valid && (!result_valid || tokens.ready);
  assign chars.ready = !hold_valid || advance;

  clt_step u_step (
    .char_in    (hold_char),
    .arg_limit  (ArgLimit),
    .state      (state),
    .result     (result_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      result_valid <= 1'b0;
      state <= '{parse_mode: MODE_WS, saved_mode: MODE_WS, arg_counter: '0};
    end else begin
      if (chars.valid && chars.ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state <= state_next;
      end else if (tokens.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      hold_char <= chars.char_in;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign tokens.valid = result_valid;
  assign tokens.char_out = result.char_out;
  assign tokens.token_start = result.token_start;
  assign tokens.arg_index = result.arg_index;
  assign tokens.arg_total = result.arg_total;
  assign tokens.segment_end = result.segment_end;
  assign tokens.line_end = result.line_end;
  assign tokens.arg_overflow = result.arg_overflow;

endmodule

### src/clt_checker.sv
// Port-level checks for the command-line tokenizer and the bind that
// attaches them to the top level. Depends on clt_pkg.
module clt_checker
  import clt_pkg::*;
#(
  parameter int MAX_ARGS = 7
) (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [7:0]      char_out,
  input logic            token_start,
  input logic [ArgW-1:0] arg_index,
  input logic [ArgW-1:0] arg_total,
  input logic            segment_end,
  input logic            line_end,
  input logic            arg_overflow
);

  localparam logic [ArgW-1:0] ArgLimit =
    (MAX_ARGS > 7) ? ArgCap : ArgW'(MAX_ARGS);

  // A stalled result item keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) &&
      $stable(token_start) && $stable(arg_index) && $stable(arg_total) &&
      $stable(segment_end) && $stable(line_end) && $stable(arg_overflow))
    else $error("stalled result item changed");

  // A counted argument is the last one in the running total.
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_start |-> !arg_overflow && arg_total == arg_index + 3'd1)
    else $error("argument start does not match the count");

  // Segment and line ends turn the byte into a terminator and never coincide.
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (segment_end || line_end) |->
      char_out == CHAR_NUL && !(segment_end && line_end) && !token_start)
    else $error("bad segment or line end");

  // The count never passes the limit, and an overflow only happens at it.
  a_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> arg_total <= ArgLimit && (!arg_overflow || arg_total == ArgLimit))
    else $error("argument count beyond the limit");

endmodule

bind command_line_tokenizer clt_checker #(.MAX_ARGS(MAX_ARGS)) u_clt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .char_out     (tokens.char_out),
  .token_start  (tokens.token_start),
  .arg_index    (tokens.arg_index),
  .arg_total    (tokens.arg_total),
  .segment_end  (tokens.segment_end),
  .line_end     (tokens.line_end),
  .arg_overflow (tokens.arg_overflow)
);
